[design/lfu_pkg.sv]
// lfu_pkg: shared types and constants for the lfu cache table
// used by lfu_cell and lfu_cache_table, no dependencies
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0]  CFG_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

  // broadcast update command from the controller to every cell
  typedef struct packed {
    logic upd;
    logic fill;
    logic store_data;
    logic age_all;
  } cell_cmd_t;

endpackage

[design/lfu_cache_table.sv]
// lfu_cache_table: key/value table with least-frequently-used replacement
// built from a row of lfu_cell entries; depends on lfu_pkg and lfu_cell
//
//   channel   handshake                  payload
//   item in   start, busy                action, key, put_value
//   result    done (one-cycle strobe)    hit, read_value
//   config    cfg_valid, cfg_ready       cfg_data (capacity in use)
//
// the key is matched over all cells at the accept edge; the cells update in
// S_UPDATE, and hit, read_value and done are registered there. a put of a new
// key into a full table first waits in S_SCAN until the settle counter shows
// the victim chain settled since the last change. reset clears valid marks at
// once, with no clearing pass. the receiver cannot stall; cfg_ready stays high.
`timescale 1ns / 1ps

module lfu_cache_table #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [lfu_pkg::KEY_W-1:0]  key,
  input  logic [lfu_pkg::DATA_W-1:0] put_value,
  output logic                       done,
  output logic                       hit,
  output logic [lfu_pkg::DATA_W-1:0] read_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_data
);
  import lfu_pkg::*;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [CMP_W-1:0] CAP_EXT   = CMP_W'(CAPACITY);
  localparam logic [OCC_W-1:0] SETTLE_MAX = OCC_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]  capacity_in_use;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  settle;
  logic              item_put;
  logic [KEY_W-1:0]  item_key;
  logic [DATA_W-1:0] item_value;
  logic [CAPACITY-1:0] match_vec;
  logic              hit_flag;
  logic [DATA_W-1:0] hit_data;
  logic [IDX_W-1:0]  hit_rank;
  logic              need_victim;

  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_sel;
  logic [DATA_W-1:0]   cell_mdata [CAPACITY];
  logic [IDX_W-1:0]    cell_mrank [CAPACITY];
  logic                tok_found [CAPACITY+1];
  logic [COUNT_BITS-1:0] tok_count [CAPACITY+1];
  logic [IDX_W-1:0]    tok_rank [CAPACITY+1];
  logic [IDX_W-1:0]    tok_idx [CAPACITY+1];

  logic              accept;
  logic              any_match;
  logic [DATA_W-1:0] any_data;
  logic [IDX_W-1:0]  any_rank;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              table_full;
  logic              settled;
  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  ref_rank;
  logic              do_replace;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign settled   = (settle == SETTLE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_in_use <= cfg_data;
    end
  end

  always_comb begin
    cfg_ext = CMP_W'(capacity_in_use);
    if (capacity_in_use == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cfg_ext > CAP_EXT) begin
      eff_cap = CAP_EXT;
    end else begin
      eff_cap = cfg_ext;
    end
    table_full = (CMP_W'(occupancy) >= eff_cap);
  end

  always_comb begin
    any_match = |cell_match;
    any_data  = '0;
    any_rank  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_data = any_data | cell_mdata[i];
      any_rank = any_rank | cell_mrank[i];
    end
  end

  // head of the victim chain
  assign tok_found[0] = 1'b0;
  assign tok_count[0] = '0;
  assign tok_rank[0]  = '0;
  assign tok_idx[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      lfu_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W),
        .CELL_INDEX (g)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .sel        (cell_sel[g]),
        .ref_rank   (ref_rank),
        .probe_key  (key),
        .wr_key     (item_key),
        .wr_data    (item_value),
        .match      (cell_match[g]),
        .match_data (cell_mdata[g]),
        .match_rank (cell_mrank[g]),
        .prev_found (tok_found[g]),
        .prev_count (tok_count[g]),
        .prev_rank  (tok_rank[g]),
        .prev_idx   (tok_idx[g]),
        .next_found (tok_found[g+1]),
        .next_count (tok_count[g+1]),
        .next_rank  (tok_rank[g+1]),
        .next_idx   (tok_idx[g+1])
      );
    end
  endgenerate

  always_comb begin
    cmd        = '0;
    cell_sel   = '0;
    ref_rank   = hit_rank;
    do_replace = 1'b0;
    if (state == S_UPDATE) begin
      if (hit_flag) begin
        cmd.upd        = 1'b1;
        cmd.store_data = item_put;
        cell_sel       = match_vec;
      end else if (item_put) begin
        cmd.upd  = 1'b1;
        cmd.fill = 1'b1;
        if (need_victim) begin
          do_replace = 1'b1;
          ref_rank   = tok_rank[CAPACITY];
          for (int i = 0; i < CAPACITY; i++) begin
            cell_sel[i] = (tok_idx[CAPACITY] == IDX_W'(i));
          end
        end else begin
          cmd.age_all = 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            cell_sel[i] = (occupancy == OCC_W'(i));
          end
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action && !any_match && table_full && !settled) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_SCAN: begin
        if (settled) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      settle    <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
      if (cmd.upd) begin
        settle <= '0;
      end else if (!settled) begin
        settle <= settle + 1'b1;
      end
      if (cmd.fill && !do_replace) begin
        occupancy <= occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_put    <= action;
      item_key    <= key;
      item_value  <= put_value;
      match_vec   <= cell_match;
      hit_flag    <= any_match;
      hit_data    <= any_data;
      hit_rank    <= any_rank;
      need_victim <= action && !any_match && table_full;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      hit <= hit_flag;
      if (item_put) begin
        read_value <= PUT_VALUE;
      end else if (hit_flag) begin
        read_value <= hit_data;
      end else begin
        read_value <= MISS_VALUE;
      end
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without an update cycle");

  a_occ_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && occupancy != $past(occupancy)) |-> done)
    else $error("occupancy changed without a result");

  a_victim_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && do_replace) |-> (settled && tok_found[CAPACITY]))
    else $error("victim taken before the search chain settled");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    accept |-> $onehot0(cell_match))
    else $error("key present in more than one entry");

endmodule

[design/lfu_cell.sv]
// lfu_cell: one table entry with key match, count/rank update and one
// stage of the victim search chain; depends on lfu_pkg
`timescale 1ns / 1ps

module lfu_cell #(
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lfu_pkg::cell_cmd_t         cmd,
  input  logic                       sel,
  input  logic [IDX_W-1:0]           ref_rank,
  input  logic [lfu_pkg::KEY_W-1:0]  probe_key,
  input  logic [lfu_pkg::KEY_W-1:0]  wr_key,
  input  logic [lfu_pkg::DATA_W-1:0] wr_data,
  output logic                       match,
  output logic [lfu_pkg::DATA_W-1:0] match_data,
  output logic [IDX_W-1:0]           match_rank,
  input  logic                       prev_found,
  input  logic [COUNT_BITS-1:0]      prev_count,
  input  logic [IDX_W-1:0]           prev_rank,
  input  logic [IDX_W-1:0]           prev_idx,
  output logic                       next_found,
  output logic [COUNT_BITS-1:0]      next_count,
  output logic [IDX_W-1:0]           next_rank,
  output logic [IDX_W-1:0]           next_idx
);
  import lfu_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [IDX_W-1:0]      MY_IDX  = IDX_W'(CELL_INDEX);

  logic                  valid;
  logic [KEY_W-1:0]      key;
  logic [DATA_W-1:0]     data;
  logic [COUNT_BITS-1:0] count;
  logic [IDX_W-1:0]      rank;
  logic                  own_better;

  assign match      = valid && (key == probe_key);
  assign match_data = match ? data : '0;
  assign match_rank = match ? rank : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.upd && sel && cmd.fill) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (sel) begin
        if (cmd.fill) begin
          key   <= wr_key;
          data  <= wr_data;
          count <= COUNT_BITS'(1);
        end else begin
          if (cmd.store_data) begin
            data <= wr_data;
          end
          if (count != CNT_MAX) begin
            count <= count + 1'b1;
          end
        end
        rank <= '0;
      end else if (valid && (cmd.age_all || rank < ref_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // victim chain: lowest count, then oldest rank
  assign own_better = valid && (!prev_found || count < prev_count ||
                      (count == prev_count && rank > prev_rank));

  always_ff @(posedge clk) begin
    if (own_better) begin
      next_found <= 1'b1;
      next_count <= count;
      next_rank  <= rank;
      next_idx   <= MY_IDX;
    end else begin
      next_found <= prev_found;
      next_count <= prev_count;
      next_rank  <= prev_rank;
      next_idx   <= prev_idx;
    end
  end

endmodule

[test/lfu_cache_table_test.sv]
// lfu_cache_table_test: self-checking regression for the lfu cache table
// drives get/put commands and capacity writes, predicts every result with a
// mirror of the table; depends on lfu_pkg and lfu_cache_table
`timescale 1ns / 1ps

module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int DEPTH = 16;
  localparam int USE_BITS = 4;
  localparam logic [USE_BITS-1:0] USE_MAX = '1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } lookup_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              action = ACT_GET;
  logic [KEY_W-1:0]  key = '0;
  logic [DATA_W-1:0] put_value = '0;
  logic              done;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = CFG_RESET;

  // mirror of the table contents
  bit                mirror_valid [DEPTH];
  logic [KEY_W-1:0]  mirror_key [DEPTH];
  logic [DATA_W-1:0] mirror_data [DEPTH];
  logic [USE_BITS-1:0] mirror_uses [DEPTH];
  int unsigned       mirror_age [DEPTH];
  int unsigned       mirror_fill;
  logic [CFG_W-1:0]  mirror_capacity;

  lookup_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  lfu_cache_table #(
    .CAPACITY(DEPTH),
    .COUNT_BITS(USE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .key(key),
    .put_value(put_value),
    .done(done),
    .hit(hit),
    .read_value(read_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void refresh_age(int slot, int unsigned limit);
    for (int i = 0; i < DEPTH; i++)
      if (mirror_valid[i] && i != slot && mirror_age[i] < limit) mirror_age[i]++;
    mirror_age[slot] = 0;
  endfunction

  function automatic lookup_result_t lfu_predict(logic is_put, logic [KEY_W-1:0] k,
                                                 logic [DATA_W-1:0] v);
    lookup_result_t r;
    int slot;
    int victim;
    int unsigned eff;
    int unsigned gone_age;
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot < 0 && mirror_valid[i] && mirror_key[i] == k) slot = i;
    r.hit = (slot >= 0);
    r.value = PUT_VALUE;
    if (is_put == ACT_GET) begin
      if (slot < 0) begin
        r.value = MISS_VALUE;
      end else begin
        r.value = mirror_data[slot];
        if (mirror_uses[slot] != USE_MAX) mirror_uses[slot]++;
        refresh_age(slot, mirror_age[slot]);
      end
      return r;
    end
    if (slot >= 0) begin
      mirror_data[slot] = v;
      if (mirror_uses[slot] != USE_MAX) mirror_uses[slot]++;
      refresh_age(slot, mirror_age[slot]);
      return r;
    end
    eff = (mirror_capacity == '0) ? 1 :
          ((32'(mirror_capacity) > DEPTH) ? DEPTH : 32'(mirror_capacity));
    if (mirror_fill >= eff) begin
      // lowest use count goes, oldest touch breaks ties
      victim = -1;
      for (int i = 0; i < DEPTH; i++)
        if (mirror_valid[i] && (victim < 0 || mirror_uses[i] < mirror_uses[victim] ||
            (mirror_uses[i] == mirror_uses[victim] && mirror_age[i] > mirror_age[victim])))
          victim = i;
      if (victim >= 0) begin
        gone_age = mirror_age[victim];
        mirror_valid[victim] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
          if (mirror_valid[i] && mirror_age[i] > gone_age) mirror_age[i]--;
        if (mirror_fill > 0) mirror_fill--;
      end
    end
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot < 0 && !mirror_valid[i]) slot = i;
    if (slot >= 0) begin
      mirror_valid[slot] = 1'b1;
      mirror_key[slot] = k;
      mirror_data[slot] = v;
      mirror_uses[slot] = USE_BITS'(1);
      refresh_age(slot, 32'hFFFF_FFFF);
      mirror_fill++;
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, lookup_result_t want, lookup_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected hit=%0b value=%h, got hit=%0b value=%h",
               $time, what, want.hit, want.value, got.hit, got.value);
  endfunction

  // result check, then prediction for a newly accepted command
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst) begin
      if (done) begin
        got.hit = hit;
        got.value = read_value;
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.value !== want.value)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) mirror_capacity = cfg_data;
      if (start && !busy) pending_results.push_back(lfu_predict(action, key, put_value));
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lfu_cache_table regression: fail");
      $finish;
    end
  end

  // one command transfer, in bursts with random gaps while gaps_on is set
  task automatic send_item(logic act, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = gaps_on ? $urandom_range(1, 16) : 64;
    end
    start <= 1'b1;
    action <= act;
    key <= k;
    put_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(ACT_GET, 32'h0000_0000, $urandom);
    send_item(ACT_GET, 32'hFFFF_FFFF, $urandom);
    send_item(ACT_GET, 32'h8000_0000, $urandom);
    send_item(ACT_GET, 32'h7FFF_FFFF, $urandom);
  endtask

  // two entries driven to the count ceiling, then a tie on eviction
  task automatic test_count_saturation();
    set_capacity(5'd2);
    gaps_on = 1'b0;
    send_item(ACT_PUT, 32'h0000_1234, 32'hAAAA_5555);
    send_item(ACT_PUT, 32'h0000_5678, 32'h5555_AAAA);
    repeat (USE_MAX) send_item(ACT_GET, 32'h0000_1234, '0);
    repeat (USE_MAX) send_item(ACT_GET, 32'h0000_5678, '0);
    send_item(ACT_GET, 32'h0000_1234, '0);
    send_item(ACT_PUT, 32'h0000_9ABC, 32'h0F0F_0F0F);
    send_item(ACT_GET, 32'h0000_5678, '0);
    send_item(ACT_GET, 32'h0000_1234, '0);
    send_item(ACT_GET, 32'h0000_9ABC, '0);
    send_item(ACT_PUT, 32'h0000_DEF0, 32'hF0F0_F0F0);
    gaps_on = 1'b1;
  endtask

  task automatic test_field_extremes();
    set_capacity(5'd16);
    send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_GET, 32'h8000_0000, $urandom);
    send_item(ACT_GET, 32'h7FFF_FFFF, $urandom);
    send_item(ACT_GET, 32'h0000_0000, $urandom);
    send_item(ACT_GET, 32'hFFFF_FFFF, $urandom);
    send_item(ACT_PUT, 32'h8000_0000, 32'h1234_5678);
    send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_lfu_order();
    set_capacity(5'd6);
    send_item(ACT_PUT, 32'h1000_0001, $urandom);
    send_item(ACT_PUT, 32'h1000_0002, $urandom);
    send_item(ACT_PUT, 32'h1000_0003, $urandom);
    send_item(ACT_GET, 32'h1000_0001, $urandom);
    send_item(ACT_GET, 32'h1000_0001, $urandom);
    send_item(ACT_GET, 32'h1000_0002, $urandom);
    send_item(ACT_PUT, 32'h1000_0004, $urandom);
    send_item(ACT_PUT, 32'h1000_0005, $urandom);
    send_item(ACT_GET, 32'h1000_0003, $urandom);
    send_item(ACT_GET, 32'h1000_0002, $urandom);
    send_item(ACT_GET, 32'h1000_0001, $urandom);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_item(ACT_PUT, 32'h2000_0001, $urandom);
    send_item(ACT_PUT, 32'h2000_0002, $urandom);
    send_item(ACT_GET, 32'h2000_0001, $urandom);
    send_item(ACT_GET, 32'h2000_0002, $urandom);
    set_capacity(5'd31);
    send_item(ACT_PUT, 32'h2000_0003, $urandom);
    send_item(ACT_PUT, 32'h2000_0004, $urandom);
    send_item(ACT_GET, 32'h2000_0003, $urandom);
    set_capacity(5'd17);
    send_item(ACT_PUT, 32'h2000_0005, $urandom);
    send_item(ACT_GET, 32'h2000_0005, $urandom);
    set_capacity(5'd1);
    send_item(ACT_PUT, 32'h2000_0006, $urandom);
    send_item(ACT_GET, 32'h2000_0006, $urandom);
  endtask

  task automatic test_capacity_shrink();
    set_capacity(5'd16);
    for (int i = 0; i < 12; i++) send_item(ACT_PUT, 32'h3000_0000 + i, $urandom);
    set_capacity(5'd4);
    send_item(ACT_PUT, 32'h3000_0100, $urandom);
    send_item(ACT_PUT, 32'h3000_0101, $urandom);
    send_item(ACT_GET, 32'h3000_000B, $urandom);
    send_item(ACT_GET, 32'h3000_0000, $urandom);
    send_item(ACT_GET, 32'h3000_0100, $urandom);
    set_capacity(5'd16);
    send_item(ACT_PUT, 32'h3000_0102, $urandom);
    send_item(ACT_PUT, 32'h3000_0103, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings [9] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12};
    logic [KEY_W-1:0] pool [20];
    logic [KEY_W-1:0] k;
    logic act;
    int unsigned eff;
    int pool_size;
    for (int p = 0; p < 9; p++) begin
      set_capacity(settings[p]);
      gaps_on = (p % 3 != 2);
      eff = (settings[p] == '0) ? 1 :
            ((32'(settings[p]) > DEPTH) ? DEPTH : 32'(settings[p]));
      pool_size = eff + 3;
      for (int j = 0; j < 20; j++) pool[j] = $urandom;
      for (int n = 0; n < 190; n++) begin
        // mostly a skewed key pool so counts spread out, some fresh keys
        if ($urandom_range(0, 9) < 8) k = pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
        else k = $urandom;
        act = ($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET;
        send_item(act, k, $urandom);
        if (n == 95) wait_drain();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i] = '0;
      mirror_data[i] = '0;
      mirror_uses[i] = '0;
      mirror_age[i] = 0;
    end
    mirror_fill = 0;
    mirror_capacity = CFG_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_count_saturation();
    test_field_extremes();
    test_lfu_order();
    test_capacity_limits();
    test_capacity_shrink();
    test_random_traffic();
    wait_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lfu_cache_table regression: pass");
    end else begin
      $display("lfu_cache_table regression: fail");
    end
    $finish;
  end

endmodule
